[design/aslv_pkg.sv]
// shared constants, types and helpers for the ais sentence line validator
// no dependencies

package aslv_pkg;

  // longest line kept, including the slot that triggers truncation
  localparam int unsigned MAX_LINE = 1024;
  localparam int unsigned CNT_W    = $clog2(MAX_LINE);
  localparam int unsigned LEN_W    = 10;

  localparam logic [7:0] CH_LEAD = 8'h21;
  localparam logic [7:0] CH_STAR = 8'h2A;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_CR   = 8'h0D;

  // input word kinds
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_EOI  = 1'b1;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  // ascii hex digit decode, either case
  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b0;
    h.val = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h41 + 8'd10);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.ok  = 1'b1;
      h.val = 4'(c - 8'h61 + 8'd10);
    end
    return h;
  endfunction

endpackage

[design/aslv_if.sv]
// valid/ready channel interfaces for the byte input and the line result
// depends on aslv_pkg

interface aslv_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, kind, data_byte, input ready);
  modport sink   (input valid, kind, data_byte, output ready);
endinterface

interface aslv_out_if;
  logic                      valid;
  logic                      ready;
  logic                      line_valid;
  logic [aslv_pkg::LEN_W-1:0] line_length;
  logic [7:0]                computed_checksum;
  logic                      truncated;

  modport source (output valid, line_valid, line_length, computed_checksum, truncated,
                  input ready);
  modport sink   (input valid, line_valid, line_length, computed_checksum, truncated,
                  output ready);
endinterface

[design/ais_sentence_line_validator.sv]
// ais sentence line validator: line assembly and nmea style checksum check
// depends on aslv_pkg and the channel interfaces in aslv_if.sv
//
// usage
// - bytes: one word per serial character (kind byte) or an end-of-input
//   marker (kind end). carriage returns are dropped, a newline closes the
//   line, end of input closes any partial line
// - lines: one word per finished line with the pass flag, kept length,
//   xor of the characters between the leading '!' and the first '*', and a
//   truncation flag. a line reaching MAX_LINE - 1 characters closes at once
//   and later bytes are thrown away up to and including the next newline
// - flow: an accepted word is held in the input register, decoded from there,
//   and its result is offered from the result register
// - throughput: one word per cycle while the result register is free or being
//   read, set by the single decode stage between the input and result registers
// - a waiting result holds in the result register; a new word is still
//   taken into the input register, and intake stops only when both are full
// - reset (rst, synchronous) empties both registers and clears line state

module ais_sentence_line_validator (
  input  logic            clk,
  input  logic            rst,
  aslv_in_if.sink         bytes,
  aslv_out_if.source      lines
);
  import aslv_pkg::*;

  // input register
  logic       q_valid;
  logic       q_kind;
  logic [7:0] q_byte;

  // line state
  logic [CNT_W-1:0] char_count, char_count_next;
  logic [7:0]       running_xor, running_xor_next;
  logic             leader_ok, leader_ok_next;
  logic             star_seen, star_seen_next;
  logic             star_too_early, star_too_early_next;
  logic [1:0]       after_star_count, after_star_count_next;
  logic [3:0]       high_nibble, high_nibble_next;
  logic             digits_ok, digits_ok_next;
  logic             discarding, discarding_next;

  // result register
  logic             out_valid;
  logic             res_ok;
  logic [LEN_W-1:0] res_len;
  logic [7:0]       res_xor;
  logic             res_trunc;

  logic             advance;
  logic             emit, emit_trunc, emit_ok;
  hex_t             hx;
  logic [LEN_W-1:0] res_len_c;
  logic [7:0]       res_xor_c;

  // stage moves when the result slot is free or being emptied
  assign advance     = !out_valid || lines.ready;
  assign bytes.ready = !q_valid || advance;

  assign hx = hex_decode(q_byte);

  always_comb begin
    logic [CNT_W-1:0] cnt;
    logic [7:0]       xr;
    logic             lo, ss, ste, dok;
    logic [1:0]       asc;
    logic [3:0]       hn;
    logic             clr;

    cnt  = char_count;
    xr   = running_xor;
    lo   = leader_ok;
    ss   = star_seen;
    ste  = star_too_early;
    asc  = after_star_count;
    hn   = high_nibble;
    dok  = digits_ok;
    clr  = 1'b0;
    emit = 1'b0;
    emit_trunc = 1'b0;
    discarding_next = discarding;

    if (q_kind == KIND_EOI) begin
      if (discarding) begin
        discarding_next = 1'b0;
        clr = 1'b1;
      end else if (char_count != '0) begin
        emit = 1'b1;
      end
    end else if (discarding) begin
      if (q_byte == CH_LF) discarding_next = 1'b0;
    end else if (q_byte == CH_LF) begin
      emit = 1'b1;
    end else if (q_byte != CH_CR) begin
      // take one character
      if (char_count == '0) begin
        lo = (q_byte == CH_LEAD);
      end else if (!star_seen) begin
        if (q_byte == CH_STAR) begin
          ss  = 1'b1;
          ste = (char_count == CNT_W'(1));
        end else if (leader_ok) begin
          xr = running_xor ^ q_byte;
        end
      end else begin
        unique case (after_star_count)
          2'd0: begin
            if (!hx.ok) dok = 1'b0;
            else hn = hx.val;
            asc = 2'd1;
          end
          2'd1: begin
            // second digit completes the checksum compare
            if (!hx.ok || {high_nibble, hx.val} != running_xor) dok = 1'b0;
            asc = 2'd2;
          end
          default: asc = 2'd3;
        endcase
      end
      cnt = char_count + CNT_W'(1);
      if (cnt == CNT_W'(MAX_LINE - 1)) begin
        discarding_next = 1'b1;
        emit       = 1'b1;
        emit_trunc = 1'b1;
      end
    end

    emit_ok = lo && ss && !ste && (asc == 2'd2) && dok;
    res_len_c = LEN_W'(cnt);
    res_xor_c = xr;

    if (emit || clr) begin
      char_count_next       = '0;
      running_xor_next      = 8'h00;
      leader_ok_next        = 1'b0;
      star_seen_next        = 1'b0;
      star_too_early_next   = 1'b0;
      after_star_count_next = 2'd0;
      high_nibble_next      = 4'h0;
      digits_ok_next        = 1'b1;
    end else begin
      char_count_next       = cnt;
      running_xor_next      = xr;
      leader_ok_next        = lo;
      star_seen_next        = ss;
      star_too_early_next   = ste;
      after_star_count_next = asc;
      high_nibble_next      = hn;
      digits_ok_next        = dok;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (bytes.ready) begin
      q_valid <= bytes.valid;
    end
    if (bytes.ready) begin
      q_kind <= bytes.kind;
      q_byte <= bytes.data_byte;
    end
  end

  // line state
  always_ff @(posedge clk) begin
    if (rst) begin
      char_count       <= '0;
      running_xor      <= 8'h00;
      leader_ok        <= 1'b0;
      star_seen        <= 1'b0;
      star_too_early   <= 1'b0;
      after_star_count <= 2'd0;
      high_nibble      <= 4'h0;
      digits_ok        <= 1'b1;
      discarding       <= 1'b0;
    end else if (advance && q_valid) begin
      char_count       <= char_count_next;
      running_xor      <= running_xor_next;
      leader_ok        <= leader_ok_next;
      star_seen        <= star_seen_next;
      star_too_early   <= star_too_early_next;
      after_star_count <= after_star_count_next;
      high_nibble      <= high_nibble_next;
      digits_ok        <= digits_ok_next;
      discarding       <= discarding_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= q_valid && emit;
    end
    if (advance && q_valid && emit) begin
      res_ok    <= emit_ok;
      res_len   <= res_len_c;
      res_xor   <= res_xor_c;
      res_trunc <= emit_trunc;
    end
  end

  assign lines.valid             = out_valid;
  assign lines.line_valid        = res_ok;
  assign lines.line_length       = res_len;
  assign lines.computed_checksum = res_xor;
  assign lines.truncated         = res_trunc;

endmodule
